FILE: sv/rtfs_pkg.sv
// types, codes and key constants for the toeplitz rss flow steering core
package rtfs_pkg;

    localparam int KEY_BITS   = 320;
    localparam int TUPLE_BITS = 288;
    localparam int HASH_W     = 32;
    localparam int CHUNKS     = TUPLE_BITS / HASH_W;
    localparam int QCOUNT_W   = 6;
    localparam int QINDEX_W   = 5;

    localparam logic [KEY_BITS-1:0] RSS_KEY = {
        64'h6d5a56da255b0ec2,
        64'h4167253d43a38fb0,
        64'hd0ca2bcbae7b30b4,
        64'h77cb2da38030f20c,
        64'h6a42b73bbeac01fa
    };

    localparam logic [1:0] L3_UNKNOWN = 2'd0;
    localparam logic [1:0] L3_IPV4    = 2'd1;
    localparam logic [1:0] L3_IPV6    = 2'd2;

    localparam logic [1:0] L4_OTHER = 2'd0;
    localparam logic [1:0] L4_TCP   = 2'd1;
    localparam logic [1:0] L4_UDP   = 2'd2;
    localparam logic [1:0] L4_SCTP  = 2'd3;

    typedef struct packed {
        logic [1:0]  l3_kind;
        logic [1:0]  l4_kind;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [31:0] verif_tag;
    } flow_t;

    typedef struct packed {
        logic [HASH_W-1:0]   hash_value;
        logic [QINDEX_W-1:0] queue_index;
    } result_t;

    typedef logic [TUPLE_BITS-1:0] tuple_t;
    typedef logic [HASH_W-1:0]     hash_t;

    // 32-bit key window that a tuple bit at position pos (0 = first bit) adds in
    function automatic hash_t key_window(input int pos);
        hash_t w;
        w = RSS_KEY[KEY_BITS-1-pos -: HASH_W];
        return w;
    endfunction

endpackage

FILE: sv/rss_toeplitz_flow_steering_core.sv
// toeplitz rss hash and queue selection, seven-stage pipeline
//
//  channel   signals                         direction  item
//  flow      flow_valid flow_stall flow      in         rtfs_pkg::flow_t
//  result    result_valid result_stall result out       rtfs_pkg::result_t
//  cfg       cfg_valid cfg_ready cfg_data    in         queue_count (6 bits)
//
// one item per cycle while result_stall is low, result registered out of the last remainder stage
// stages: tuple select, 9 partial hashes of 32 bits, partial fold, 4 stages of
// 8 restoring remainder steps each
// each stage holds its item until the next stage frees, so bubbles collapse
// reset clears all valid bits and sets queue_count to 1
module rss_toeplitz_flow_steering_core
    import rtfs_pkg::*;
#(
    parameter int MAX_QUEUES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                flow_valid,
    output logic                flow_stall,
    input  flow_t               flow,
    output logic                result_valid,
    input  logic                result_stall,
    output result_t             result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [QCOUNT_W-1:0] cfg_data
);

    localparam int DIV_STAGES = HASH_W / 8;
    localparam int DIV_STEPS  = HASH_W / DIV_STAGES;

    logic [QCOUNT_W-1:0] queue_count_reg;
    logic [QCOUNT_W-1:0] n_eff;

    logic   v1_reg;
    tuple_t tup1_reg;
    tuple_t tup1_next;
    logic   rdy1;

    logic  v2_reg;
    hash_t part2_reg [CHUNKS];
    hash_t part2_next [CHUNKS];
    logic  rdy2;

    logic  v3_reg;
    hash_t hash3_reg;
    hash_t hash3_next;
    logic  rdy3;

    logic                dv_reg   [DIV_STAGES];
    hash_t               dh_reg   [DIV_STAGES];
    logic [QCOUNT_W-1:0] dr_reg   [DIV_STAGES];
    logic [QCOUNT_W-1:0] dr_next  [DIV_STAGES];
    logic                rdyd     [DIV_STAGES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_count_reg <= QCOUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            queue_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        priority if (queue_count_reg == '0)
        begin
            n_eff = QCOUNT_W'(1);
        end
        else if ({1'b0, queue_count_reg} > (QCOUNT_W+1)'(MAX_QUEUES))
        begin
            n_eff = QCOUNT_W'(MAX_QUEUES);
        end
        else
        begin
            n_eff = queue_count_reg;
        end
    end

    // ready chain from the output back
    always_comb
    begin
        rdyd[DIV_STAGES-1] = !dv_reg[DIV_STAGES-1] || !result_stall;
        for (int d = DIV_STAGES - 2; d >= 0; d--)
        begin
            rdyd[d] = !dv_reg[d] || rdyd[d+1];
        end
        rdy3 = !v3_reg || rdyd[0];
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
    end

    assign flow_stall = !rdy1;

    // tuple select, first bit of the tuple in the msb
    always_comb
    begin
        logic [31:0] l4_word;
        unique case (flow.l4_kind)
            L4_TCP, L4_UDP: l4_word = {flow.l4_sport, flow.l4_dport};
            L4_SCTP:        l4_word = flow.verif_tag;
            default:        l4_word = '0;
        endcase
        unique case (flow.l3_kind)
            L3_IPV4:
            begin
                tup1_next = {flow.src_addr_lo[31:0], flow.dst_addr_lo[31:0], l4_word,
                             (TUPLE_BITS-96)'(0)};
            end
            L3_IPV6:
            begin
                tup1_next = {flow.src_addr_hi, flow.src_addr_lo,
                             flow.dst_addr_hi, flow.dst_addr_lo, l4_word};
            end
            default:
            begin
                tup1_next = '0;
            end
        endcase
    end

    // partial hash per 32-bit chunk of the tuple
    always_comb
    begin
        for (int c = 0; c < CHUNKS; c++)
        begin
            part2_next[c] = '0;
            for (int i = 0; i < HASH_W; i++)
            begin
                if (tup1_reg[TUPLE_BITS-1-(c*HASH_W+i)])
                begin
                    part2_next[c] = part2_next[c] ^ key_window(c*HASH_W + i);
                end
            end
        end
    end

    always_comb
    begin
        hash3_next = '0;
        for (int c = 0; c < CHUNKS; c++)
        begin
            hash3_next = hash3_next ^ part2_reg[c];
        end
    end

    // restoring remainder, eight quotient bits per stage
    always_comb
    begin
        hash_t               h;
        logic [QCOUNT_W-1:0] r;
        logic [QCOUNT_W:0]   t;
        for (int d = 0; d < DIV_STAGES; d++)
        begin
            h = (d == 0) ? hash3_reg : dh_reg[d-1];
            r = (d == 0) ? '0 : dr_reg[d-1];
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                t = {r, h[HASH_W-1-(d*DIV_STEPS+k)]};
                if (t >= {1'b0, n_eff})
                begin
                    t = t - {1'b0, n_eff};
                end
                r = t[QCOUNT_W-1:0];
            end
            dr_next[d] = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int d = 0; d < DIV_STAGES; d++)
            begin
                dv_reg[d] <= 1'b0;
            end
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= flow_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdyd[0])
            begin
                dv_reg[0] <= v3_reg;
            end
            for (int d = 1; d < DIV_STAGES; d++)
            begin
                if (rdyd[d])
                begin
                    dv_reg[d] <= dv_reg[d-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            tup1_reg <= tup1_next;
        end
        if (rdy2)
        begin
            part2_reg <= part2_next;
        end
        if (rdy3)
        begin
            hash3_reg <= hash3_next;
        end
        if (rdyd[0])
        begin
            dh_reg[0] <= hash3_reg;
            dr_reg[0] <= dr_next[0];
        end
        for (int d = 1; d < DIV_STAGES; d++)
        begin
            if (rdyd[d])
            begin
                dh_reg[d] <= dh_reg[d-1];
                dr_reg[d] <= dr_next[d];
            end
        end
    end

    assign result_valid       = dv_reg[DIV_STAGES-1];
    assign result.hash_value  = dh_reg[DIV_STAGES-1];
    assign result.queue_index = dr_reg[DIV_STAGES-1][QINDEX_W-1:0];

endmodule

FILE: tb/rss_toeplitz_flow_steering_core_test.sv
// self-checking testbench for the toeplitz rss hash and queue steering core
`timescale 1ns / 100ps

module rss_toeplitz_flow_steering_core_test;

    import rtfs_pkg::*;

    localparam int QUEUE_LIMIT    = 32;
    localparam int FLOWS_PER_PASS = 100;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 300;
    localparam int CYCLE_LIMIT    = 400000;

    localparam logic [1:0] L3_RESERVED = 2'd3;

    localparam logic [319:0] DEFAULT_KEY = {
        64'h6d5a56da255b0ec2,
        64'h4167253d43a38fb0,
        64'hd0ca2bcbae7b30b4,
        64'h77cb2da38030f20c,
        64'h6a42b73bbeac01fa
    };

    logic                clk;
    logic                rst_n = 1'b0;
    logic                flow_valid = 1'b0;
    logic                flow_stall;
    flow_t               flow = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    result_t             result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [QCOUNT_W-1:0] cfg_data = '0;

    flow_t               flow_backlog[$];
    result_t             hashes_due[$];
    logic [QCOUNT_W-1:0] queue_count = 6'd1;
    int                  sender_idle_pct = 0;
    int                  receiver_idle_pct = 0;
    int                  hold_left = 0;
    int                  mismatches = 0;
    int                  results_checked = 0;
    int                  cycles = 0;
    int                  ipv4_flows = 0;
    int                  ipv6_flows = 0;
    int                  unknown_flows = 0;
    int                  settings_used = 1;

    rss_toeplitz_flow_steering_core #(
        .MAX_QUEUES(QUEUE_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .flow_valid(flow_valid),
        .flow_stall(flow_stall),
        .flow(flow),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    function automatic result_t steer_flow(input flow_t f, input logic [QCOUNT_W-1:0] qcount);
        logic [287:0] tuple;
        logic [31:0]  h;
        logic [31:0]  n;
        logic [31:0]  rem;
        int           nbits;
        int           i;
        result_t      r;
        tuple = '0;
        h = '0;
        nbits = 0;
        if (f.l3_kind == L3_IPV4 || f.l3_kind == L3_IPV6)
        begin
            if (f.l3_kind == L3_IPV4)
            begin
                tuple[287 -: 64] = {f.src_addr_lo[31:0], f.dst_addr_lo[31:0]};
                nbits = 64;
            end
            else
            begin
                tuple[287 -: 256] = {f.src_addr_hi, f.src_addr_lo, f.dst_addr_hi, f.dst_addr_lo};
                nbits = 256;
            end
            if (f.l4_kind == L4_TCP || f.l4_kind == L4_UDP)
            begin
                tuple[287 - nbits -: 32] = {f.l4_sport, f.l4_dport};
                nbits += 32;
            end
            else if (f.l4_kind == L4_SCTP)
            begin
                tuple[287 - nbits -: 32] = f.verif_tag;
                nbits += 32;
            end
            for (i = 0; i < nbits; i++)
            begin
                if (tuple[287 - i])
                    h ^= DEFAULT_KEY[319 - i -: 32];
            end
        end
        n = {26'd0, qcount};
        if (n == 0)
            n = 1;
        if (n > QUEUE_LIMIT)
            n = QUEUE_LIMIT;
        rem = h % n;
        r.hash_value = h;
        r.queue_index = rem[QINDEX_W-1:0];
        return r;
    endfunction

    function automatic logic [63:0] wide_random();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic flow_t random_flow();
        flow_t f;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 45)
            f.l3_kind = L3_IPV4;
        else if (pick < 90)
            f.l3_kind = L3_IPV6;
        else if (pick < 95)
            f.l3_kind = L3_UNKNOWN;
        else
            f.l3_kind = L3_RESERVED;
        f.l4_kind = 2'($urandom_range(3));
        f.src_addr_hi = wide_random();
        f.src_addr_lo = wide_random();
        f.dst_addr_hi = wide_random();
        f.dst_addr_lo = wide_random();
        f.l4_sport = 16'(wide_random());
        f.l4_dport = 16'(wide_random());
        f.verif_tag = 32'(wide_random());
        return f;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (flow_backlog.size() != 0 || flow_valid || hashes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_queue_count(input logic [QCOUNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        queue_count = value;
        settings_used++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // flow driver
    always @(posedge clk)
    begin
        if (rst_n && (!flow_valid || !flow_stall))
        begin
            if (flow_valid)
            begin
                hashes_due.push_back(steer_flow(flow, queue_count));
                if (flow.l3_kind == L3_IPV4)
                    ipv4_flows++;
                else if (flow.l3_kind == L3_IPV6)
                    ipv6_flows++;
                else
                    unknown_flows++;
            end
            if (flow_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                flow_valid <= 1'b1;
                flow <= flow_backlog.pop_front();
            end
            else
                flow_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (hashes_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result hash %h queue %0d", $time,
                             result.hash_value, result.queue_index);
                end
                else
                begin
                    want = hashes_due.pop_front();
                    results_checked++;
                    if (result.hash_value !== want.hash_value)
                    begin
                        mismatches++;
                        $display("%0t: hash_value expected %h actual %h", $time,
                                 want.hash_value, result.hash_value);
                    end
                    if (result.queue_index !== want.queue_index)
                    begin
                        mismatches++;
                        $display("%0t: queue_index expected %0d actual %0d", $time,
                                 want.queue_index, result.queue_index);
                    end
                end
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                result_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     hashes_due.size());
            $display("rss_toeplitz_flow_steering_core_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [QCOUNT_W-1:0] settings[8];
        flow_t               f;
        int                  k;
        int                  pass;
        settings = '{6'd1, 6'd32, 6'd0, 6'd5, 6'd63, 6'd33, 6'd1, 6'd0};
        settings[7] = 6'($urandom_range(2, 31));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        sender_idle_pct = 36;
        receiver_idle_pct = 57;
        for (k = 0; k < 16; k++)
        begin
            f = (k % 3 == 0) ? '1 : random_flow();
            f.l3_kind = 2'(k >> 2);
            f.l4_kind = 2'(k);
            flow_backlog.push_back(f);
        end
        f = '0;
        f.l3_kind = L3_IPV6;
        f.l4_kind = L4_TCP;
        flow_backlog.push_back(f);
        f.l3_kind = L3_IPV4;
        f.l4_kind = L4_UDP;
        flow_backlog.push_back(f);
        // ipv4 with every ignored upper bit set
        f = '1;
        f.src_addr_lo[31:0] = '0;
        f.dst_addr_lo[31:0] = 32'h0a000001;
        f.l3_kind = L3_IPV4;
        f.l4_kind = L4_SCTP;
        flow_backlog.push_back(f);

        for (pass = 0; pass < 8; pass++)
        begin
            if (pass > 0)
            begin
                wait_drained();
                write_queue_count(settings[pass]);
                @(negedge clk);
            end
            if (pass >= 3 && pass < 5)
            begin
                sender_idle_pct = 57;
                receiver_idle_pct = 36;
            end
            else if (pass >= 5)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            if (pass == 5)
                hold_left = LONG_HOLD;
            for (k = 0; k < FLOWS_PER_PASS; k++)
            begin
                flow_backlog.push_back(random_flow());
                // sender pauses mid-pass until everything has drained
                if (pass == 3 && k == FLOWS_PER_PASS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        $display("checked %0d results over %0d queue count settings", results_checked,
                 settings_used);
        $display("flows: %0d ipv4, %0d ipv6, %0d unknown l3", ipv4_flows, ipv6_flows,
                 unknown_flows);
        if (mismatches == 0)
            $display("rss_toeplitz_flow_steering_core_test OK");
        else
            $display("rss_toeplitz_flow_steering_core_test NOT OK");
        $finish;
    end

endmodule
